FILE: rtl/ucts_pkg.sv
// Package for the USB control transfer sequencer: codes, widths and reset values.
// Used by usb_control_transfer_sequencer_top; depends on nothing else.
package ucts_pkg;

   // Widths of the fields and registers
   localparam int EpW      = 4;
   localparam int LenW     = 16;
   localparam int CodeW    = 4;
   localparam int CountW   = 7;
   localparam int ActW     = 3;
   localparam int NakW     = 16;
   localparam int RetryW   = 8;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 16;
   localparam int ReqDataW = 32;
   localparam int RspDataW = 48;

   // Largest packet accepted into the byte total
   localparam int MaxPacketBytesDefault = 64;

   // Register reset values
   localparam logic [NakW-1:0]   NakLimitReset      = 16'd200;
   localparam logic [RetryW-1:0] RetryLimitReset    = 8'd3;
   localparam logic [CountW-1:0] MaxPacketSizeReset = 7'd8;
   localparam logic [CodeW-1:0]  NakCodeReset       = 4'd4;
   localparam logic [CodeW-1:0]  TimeoutCodeReset   = 4'd14;

   localparam logic [CodeW-1:0]  CodeAck = 4'd0;

   // Register indexes on the configuration port
   typedef enum logic [CsrIdxW-1:0] {
      CSR_NAK_LIMIT   = 3'd0,
      CSR_RETRY_LIMIT = 3'd1,
      CSR_MAX_PACKET  = 3'd2,
      CSR_NAK_CODE    = 3'd3,
      CSR_TIMEOUT     = 3'd4
   } csr_index_type;

   // Request kinds
   typedef enum logic [1:0] {
      REQ_START_READ  = 2'd0,
      REQ_START_WRITE = 2'd1,
      REQ_COMPLETE    = 2'd2,
      REQ_UNUSED      = 2'd3
   } req_kind_type;

   // Actions reported on the result channel
   typedef enum logic [ActW-1:0] {
      ACT_SETUP      = 3'd0,
      ACT_IN_DATA    = 3'd1,
      ACT_OUT_STATUS = 3'd2,
      ACT_IN_STATUS  = 3'd3,
      ACT_DONE       = 3'd4
   } action_type;

   // One result word
   typedef struct packed {
      logic [NakW-1:0]   data_stage_naks;
      logic [LenW-1:0]   transferred_bytes;
      logic [CodeW-1:0]  result_status;
      logic              set_data1;
      logic [EpW-1:0]    launch_endpoint;
      action_type        action;
   } result_type;

endpackage

FILE: rtl/usb_control_transfer_sequencer_top.sv
// Host-side USB control transfer sequencer with NAK and timeout retry.
// Each result word is registered, in the skid register if the output is stalled.
// Throughput: one request word per cycle while the skid register is empty (req_tready high).
// A two-entry output stage (output register plus skid register) keeps req_tready registered.
// Reset (synchronous, active high) returns to idle with the register defaults loaded.
// Depends on ucts_pkg.
module usb_control_transfer_sequencer_top #(
   parameter int MAX_PACKET_BYTES = ucts_pkg::MaxPacketBytesDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // target_endpoint[3:0], request_length[19:4], handshake_code[23:20],
   // received_count[30:24], zero fill [31]
   input  logic [ucts_pkg::ReqDataW-1:0]  req_tdata,
   // req_type[1:0]
   input  logic [1:0]                     req_tuser,
   // Result channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // launch_endpoint[3:0], set_data1[4], result_status[8:5],
   // transferred_bytes[24:9], data_stage_naks[40:25], zero fill [47:41]
   output logic [ucts_pkg::RspDataW-1:0]  rsp_tdata,
   // action[2:0]
   output logic [ucts_pkg::ActW-1:0]      rsp_tuser,
   // Configuration port
   input  logic                           csr_we,
   input  logic [ucts_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [ucts_pkg::CsrDataW-1:0]  csr_wdata
);
   import ucts_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE, PH_SETUP, PH_DATA, PH_STAT_OUT, PH_STAT_IN
   } phase_type;

   // Configuration registers
   logic [NakW-1:0]   nak_max_ff;
   logic [RetryW-1:0] retry_max_ff;
   logic [CountW-1:0] max_packet_ff;
   logic [CodeW-1:0]  nak_code_ff;
   logic [CodeW-1:0]  timeout_code_ff;

   // Transfer state
   phase_type         phase_ff, phase_in;
   logic              is_write_ff, is_write_in;
   logic [NakW-1:0]   nak_cnt_ff, nak_cnt_in;
   logic [RetryW-1:0] tmo_cnt_ff, tmo_cnt_in;
   logic [LenW-1:0]   bytes_ff, bytes_in;
   logic [LenW-1:0]   wanted_ff, wanted_in;
   logic [EpW-1:0]    ep_ff, ep_in;
   logic [NakW-1:0]   saved_naks_ff, saved_naks_in;

   // Output stage
   logic              out_valid_ff, out_valid_in;
   result_type        out_ff, out_in;
   logic              skid_valid_ff, skid_valid_in;
   result_type        skid_ff, skid_in;

   // Request word fields
   req_kind_type      kind;
   logic [EpW-1:0]    f_ep;
   logic [LenW-1:0]   f_len;
   logic [CodeW-1:0]  f_hs;
   logic [CountW-1:0] f_rc;

   logic              accept;
   logic              emit;
   result_type        res;
   action_type        act;
   logic              d1;
   logic [CodeW-1:0]  status;
   action_type        retry_act;
   logic [NakW-1:0]   nak_inc;
   logic [RetryW-1:0] tmo_inc;
   logic [CountW-1:0] pkt;
   logic [LenW:0]     sum;
   logic [LenW-1:0]   sum_sat;

   assign kind  = req_kind_type'(req_tuser);
   assign f_ep  = req_tdata[3:0];
   assign f_len = req_tdata[19:4];
   assign f_hs  = req_tdata[23:20];
   assign f_rc  = req_tdata[30:24];

   assign req_tready = ~skid_valid_ff;
   assign accept     = req_tvalid & req_tready;

   // Token that a retry relaunches
   always_comb begin
      unique case (phase_ff)
         PH_SETUP:    retry_act = ACT_SETUP;
         PH_DATA:     retry_act = ACT_IN_DATA;
         PH_STAT_OUT: retry_act = ACT_OUT_STATUS;
         default:     retry_act = ACT_IN_STATUS;
      endcase
   end

   // Saturating counters, packet clamp and byte sum
   assign nak_inc = (nak_cnt_ff == '1) ? nak_cnt_ff : nak_cnt_ff + 1'b1;
   assign tmo_inc = (tmo_cnt_ff == '1) ? tmo_cnt_ff : tmo_cnt_ff + 1'b1;
   assign pkt     = (32'(f_rc) > MAX_PACKET_BYTES) ? CountW'(MAX_PACKET_BYTES) : f_rc;
   assign sum     = {1'b0, bytes_ff} + (LenW+1)'(pkt);
   assign sum_sat = sum[LenW] ? '1 : sum[LenW-1:0];

   // Sequencer next state and result
   always_comb begin
      phase_in      = phase_ff;
      is_write_in   = is_write_ff;
      nak_cnt_in    = nak_cnt_ff;
      tmo_cnt_in    = tmo_cnt_ff;
      bytes_in      = bytes_ff;
      wanted_in     = wanted_ff;
      ep_in         = ep_ff;
      saved_naks_in = saved_naks_ff;
      emit          = 1'b0;
      act           = ACT_DONE;
      d1            = 1'b0;
      status        = CodeAck;
      if (kind == REQ_START_READ || kind == REQ_START_WRITE) begin
         is_write_in   = (kind == REQ_START_WRITE);
         ep_in         = f_ep;
         wanted_in     = (kind == REQ_START_READ) ? f_len : '0;
         bytes_in      = '0;
         saved_naks_in = '0;
         nak_cnt_in    = '0;
         tmo_cnt_in    = '0;
         phase_in      = PH_SETUP;
         emit          = 1'b1;
         act           = ACT_SETUP;
      end else if (kind == REQ_COMPLETE && phase_ff != PH_IDLE) begin
         emit = 1'b1;
         priority if (f_hs == nak_code_ff) begin
            nak_cnt_in = nak_inc;
            if (nak_inc >= nak_max_ff) begin
               phase_in = PH_IDLE;
               act      = ACT_DONE;
               status   = f_hs;
            end else begin
               act = retry_act;
            end
         end else if (f_hs == timeout_code_ff) begin
            tmo_cnt_in = tmo_inc;
            if (tmo_inc >= retry_max_ff) begin
               phase_in = PH_IDLE;
               act      = ACT_DONE;
               status   = f_hs;
            end else begin
               act = retry_act;
            end
         end else if (f_hs != CodeAck) begin
            phase_in = PH_IDLE;
            act      = ACT_DONE;
            status   = f_hs;
         end else if (phase_ff == PH_SETUP) begin
            nak_cnt_in = '0;
            tmo_cnt_in = '0;
            if (is_write_ff) begin
               phase_in = PH_STAT_IN;
               act      = ACT_IN_STATUS;
            end else begin
               phase_in = PH_DATA;
               act      = ACT_IN_DATA;
               d1       = 1'b1;
            end
         end else if (phase_ff == PH_DATA) begin
            bytes_in   = sum_sat;
            nak_cnt_in = '0;
            tmo_cnt_in = '0;
            if (pkt < max_packet_ff || sum_sat >= wanted_ff) begin
               saved_naks_in = nak_cnt_ff;
               phase_in      = PH_STAT_OUT;
               act           = ACT_OUT_STATUS;
            end else begin
               act = ACT_IN_DATA;
            end
         end else begin
            phase_in = PH_IDLE;
            act      = ACT_DONE;
         end
      end
   end

   assign res = '{data_stage_naks:   saved_naks_in,
                  transferred_bytes: bytes_in,
                  result_status:     status,
                  set_data1:         d1,
                  launch_endpoint:   ep_in,
                  action:            act};

   // Output register and skid register
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in  = skid_valid_ff;
         out_in        = skid_ff;
         skid_valid_in = 1'b0;
      end
      if (accept && emit) begin
         if (out_valid_in) begin
            skid_valid_in = 1'b1;
            skid_in       = res;
         end else begin
            out_valid_in = 1'b1;
            out_in       = res;
         end
      end
   end

   // Configuration registers, sequencer state and output stage
   always_ff @(posedge clock) begin
      if (reset) begin
         nak_max_ff      <= NakLimitReset;
         retry_max_ff    <= RetryLimitReset;
         max_packet_ff   <= MaxPacketSizeReset;
         nak_code_ff     <= NakCodeReset;
         timeout_code_ff <= TimeoutCodeReset;
         phase_ff        <= PH_IDLE;
         is_write_ff     <= 1'b0;
         nak_cnt_ff      <= '0;
         tmo_cnt_ff      <= '0;
         bytes_ff        <= '0;
         wanted_ff       <= '0;
         ep_ff           <= '0;
         saved_naks_ff   <= '0;
         out_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_NAK_LIMIT:   nak_max_ff      <= csr_wdata;
               CSR_RETRY_LIMIT: retry_max_ff    <= csr_wdata[RetryW-1:0];
               CSR_MAX_PACKET:  max_packet_ff   <= csr_wdata[CountW-1:0];
               CSR_NAK_CODE:    nak_code_ff     <= csr_wdata[CodeW-1:0];
               CSR_TIMEOUT:     timeout_code_ff <= csr_wdata[CodeW-1:0];
               default: ;
            endcase
         end
         if (accept) begin
            phase_ff      <= phase_in;
            is_write_ff   <= is_write_in;
            nak_cnt_ff    <= nak_cnt_in;
            tmo_cnt_ff    <= tmo_cnt_in;
            bytes_ff      <= bytes_in;
            wanted_ff     <= wanted_in;
            ep_ff         <= ep_in;
            saved_naks_ff <= saved_naks_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.action;
   assign rsp_tdata  = {7'd0, out_ff.data_stage_naks, out_ff.transferred_bytes,
                        out_ff.result_status, out_ff.set_data1, out_ff.launch_endpoint};

   // The skid register only fills behind a full output register.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a word while the output register is empty");

   // A result arriving while the output is stalled lands in the skid register.
   a_stall_to_skid: assert property (@(posedge clock) disable iff (reset)
      (accept && emit && out_valid_ff && !rsp_tready) |=> skid_valid_ff)
      else $error("result word lost during output stall");

   // A done result always leaves the sequencer idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && emit && act == ACT_DONE) |=> phase_ff == PH_IDLE)
      else $error("sequencer not idle after a done result");

   // The DATA1 flag only goes with an IN data launch right after SETUP.
   a_data1_first_in: assert property (@(posedge clock) disable iff (reset)
      (accept && emit && d1) |-> (act == ACT_IN_DATA && phase_ff == PH_SETUP))
      else $error("set_data1 raised outside the first data IN launch");

endmodule
